FILE: sv/pesi_pkg.sv
package pesi_pkg;

    localparam int NUM_ELEMENTS = 4;
    localparam int NUM_BINS     = 1024;

    localparam int ELEM_W  = 2;
    localparam int BIN_W   = 10;
    localparam int POWER_W = 32;
    localparam int SAMP_W  = 16;
    localparam int LEN_W   = 16;
    localparam int ACC_W   = 48;
    localparam int TOTAL_W = 32;

    localparam int ACC_DEPTH  = NUM_ELEMENTS * NUM_BINS;
    localparam int ADDR_W     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int ELEM_IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

endpackage

FILE: sv/pesi_ram.sv
module pesi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/per_element_spectrum_integrator.sv
// Integrate-and-dump of power spectra, one bin per beat, one beat per cycle while the
// input is not stalled. Each bin does a read-modify-write of its 48-bit accumulator in
// a single RAM of NUM_ELEMENTS*NUM_BINS entries: the read is issued when the beat is
// accepted and the sum is written back when the beat leaves stage 1, with a forwarding
// register covering a repeat of the same bin in the next beat. A dumped bin is loaded
// into the output register as its beat leaves stage 1; while that register is full
// and stalled, the input is stalled too.
// After reset the accumulator RAM is swept to zero, one entry per cycle, and the
// input stalls until the NUM_ELEMENTS*NUM_BINS entries (4096 by default) are clear.
// The integration length may be written at any time the block is idle; zero acts as one.
module per_element_spectrum_integrator
    import pesi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ELEM_W-1:0]  i_element_index,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [POWER_W-1:0] i_power_value,
    input  logic [SAMP_W-1:0]  i_packet_samples,
    input  logic               i_end_of_packet,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ELEM_W-1:0]  o_out_element,
    output logic [BIN_W-1:0]   o_out_bin,
    output logic [ACC_W-1:0]   o_summed_power,
    output logic [TOTAL_W-1:0] o_total_samples,
    output logic               o_last_of_spectrum
);

    localparam logic [ACC_W-1:0]   ACC_MAX  = '1;
    localparam logic [TOTAL_W-1:0] SAMP_MAX = '1;

    // configuration
    logic [LEN_W-1:0] r_len;

    // clearing sweep
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // per-element counters
    logic [LEN_W-1:0]   r_cnt  [NUM_ELEMENTS];
    logic [TOTAL_W-1:0] r_samp [NUM_ELEMENTS];

    // stage 1: read data back from the RAM
    logic                  r_s1_vld;
    logic [ELEM_W-1:0]     r_s1_elem;
    logic [ELEM_IDX_W-1:0] r_s1_eidx;
    logic [BIN_W-1:0]      r_s1_bin;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic [POWER_W-1:0]    r_s1_power;
    logic [SAMP_W-1:0]     r_s1_samples;
    logic                  r_s1_eop;

    // forwarding of the write made at the same edge as this beat's read
    logic             r_fwd_vld;
    logic [ACC_W-1:0] r_fwd_data;

    // output register
    logic               r_out_vld;
    logic [ELEM_W-1:0]  r_out_elem;
    logic [BIN_W-1:0]   r_out_bin;
    logic [ACC_W-1:0]   r_out_power;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_last;

    logic              adv;
    logic              accept;
    logic              in_ok;
    logic [ADDR_W-1:0] in_addr;

    logic [ACC_W-1:0]   ram_rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ACC_W-1:0]   ram_wdata;

    logic [ACC_W-1:0]   acc;
    logic [ACC_W:0]     sum_ext;
    logic [ACC_W-1:0]   sum;
    logic [LEN_W-1:0]   cnt;
    logic               dump;
    logic [TOTAL_W:0]   samp_ext;
    logic [TOTAL_W-1:0] samp_sum;
    logic [ACC_W-1:0]   s1_wdata;
    logic               s1_fire;

    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_clearing || !adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign in_ok   = (int'(i_element_index) < NUM_ELEMENTS) && (int'(i_bin_index) < NUM_BINS);
    assign in_addr = ADDR_W'(ADDR_W'(i_element_index) * ADDR_W'(NUM_BINS))
                   + ADDR_W'(i_bin_index);

    always_comb begin
        acc      = r_fwd_vld ? r_fwd_data : ram_rdata;
        sum_ext  = {1'b0, acc} + (ACC_W + 1)'(r_s1_power);
        sum      = sum_ext[ACC_W] ? ACC_MAX : sum_ext[ACC_W-1:0];
        cnt      = r_cnt[r_s1_eidx];
        // a zero length makes every packet dump
        dump     = ((LEN_W + 1)'(cnt) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(r_len);
        samp_ext = {1'b0, r_samp[r_s1_eidx]} + (TOTAL_W + 1)'(r_s1_samples);
        samp_sum = samp_ext[TOTAL_W] ? SAMP_MAX : samp_ext[TOTAL_W-1:0];
        s1_wdata = dump ? '0 : sum;
        s1_fire  = r_s1_vld && adv;
    end

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_fire;
            ram_waddr = r_s1_addr;
            ram_wdata = s1_wdata;
        end
    end

    pesi_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH),
        .AW    (ADDR_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < NUM_ELEMENTS; i++) begin
                r_cnt[i]  <= '0;
                r_samp[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (int'(r_clr_addr) == ACC_DEPTH - 1) begin
                    r_clearing <= 1'b0;
                end
            end

            if (adv) begin
                r_s1_vld  <= accept && in_ok;
                r_fwd_vld <= r_s1_vld && accept && (r_s1_addr == in_addr);
                r_out_vld <= r_s1_vld && dump;
            end

            if (s1_fire && r_s1_eop) begin
                if (dump) begin
                    r_cnt[r_s1_eidx]  <= '0;
                    r_samp[r_s1_eidx] <= '0;
                end else begin
                    r_cnt[r_s1_eidx]  <= cnt + LEN_W'(1);
                    r_samp[r_s1_eidx] <= samp_sum;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_elem    <= i_element_index;
            r_s1_eidx    <= ELEM_IDX_W'(i_element_index);
            r_s1_bin     <= i_bin_index;
            r_s1_addr    <= in_addr;
            r_s1_power   <= i_power_value;
            r_s1_samples <= i_packet_samples;
            r_s1_eop     <= i_end_of_packet;
            r_fwd_data   <= s1_wdata;
            r_out_elem   <= r_s1_elem;
            r_out_bin    <= r_s1_bin;
            r_out_power  <= sum;
            r_out_total  <= r_s1_eop ? samp_sum : '0;
            r_out_last   <= r_s1_eop;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_out_element      = r_out_elem;
    assign o_out_bin          = r_out_bin;
    assign o_summed_power     = r_out_power;
    assign o_total_samples    = r_out_total;
    assign o_last_of_spectrum = r_out_last;

endmodule

FILE: tb/sv/spectrum_integrator_checker.sv
module spectrum_integrator_checker
    import pesi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [ELEM_W-1:0]  i_element_index,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [POWER_W-1:0] i_power_value,
    input  logic [SAMP_W-1:0]  i_packet_samples,
    input  logic               i_end_of_packet,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [ELEM_W-1:0]  i_out_element,
    input  logic [BIN_W-1:0]   i_out_bin,
    input  logic [ACC_W-1:0]   i_summed_power,
    input  logic [TOTAL_W-1:0] i_total_samples,
    input  logic               i_last_of_spectrum,

    output int                 o_mismatch_count,
    output int                 o_waiting_count
);

    localparam logic [ACC_W-1:0]   POWER_TOP = {ACC_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_TOP = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [ELEM_W-1:0]  element;
        logic [BIN_W-1:0]   bin_no;
        logic [ACC_W-1:0]   power;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_spectrum_bin;

    logic [ACC_W-1:0]   power_acc [ACC_DEPTH];
    logic [LEN_W-1:0]   packet_count [NUM_ELEMENTS];
    logic [TOTAL_W-1:0] sample_total [NUM_ELEMENTS];
    logic [LEN_W-1:0]   integ_len;
    t_spectrum_bin      expected_bins [$];
    t_spectrum_bin      oldest_bin;
    int                 mismatches;

    function automatic logic [TOTAL_W-1:0] add_samples(input logic [TOTAL_W-1:0] acc,
                                                       input logic [SAMP_W-1:0]  samples);
        logic [TOTAL_W:0] wide;
        wide = {1'b0, acc} + (TOTAL_W+1)'(samples);
        return wide[TOTAL_W] ? TOTAL_TOP : wide[TOTAL_W-1:0];
    endfunction

    task automatic integrate_beat(input logic [ELEM_W-1:0]  elem,
                                  input logic [BIN_W-1:0]   bin_no,
                                  input logic [POWER_W-1:0] power,
                                  input logic [SAMP_W-1:0]  samples,
                                  input logic               eop);
        int               slot;
        logic [ACC_W:0]   wide;
        logic [ACC_W-1:0] acc_sum;
        t_spectrum_bin    dumped;
        if (int'(elem) < NUM_ELEMENTS && int'(bin_no) < NUM_BINS) begin
            slot    = int'(elem) * NUM_BINS + int'(bin_no);
            wide    = {1'b0, power_acc[slot]} + (ACC_W+1)'(power);
            acc_sum = wide[ACC_W] ? POWER_TOP : wide[ACC_W-1:0];
            // the packet that completes the count dumps; a zero length behaves as one
            if (int'(packet_count[elem]) + 1 < int'(integ_len)) begin
                power_acc[slot] = acc_sum;
                if (eop) begin
                    sample_total[elem] = add_samples(sample_total[elem], samples);
                    packet_count[elem] = packet_count[elem] + 1'b1;
                end
            end else begin
                power_acc[slot] = '0;
                dumped.element  = elem;
                dumped.bin_no   = bin_no;
                dumped.power    = acc_sum;
                dumped.total    = eop ? add_samples(sample_total[elem], samples) : '0;
                dumped.last     = eop;
                if (eop) begin
                    sample_total[elem] = '0;
                    packet_count[elem] = '0;
                end
                expected_bins.push_back(dumped);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (power_acc[k]) power_acc[k] = '0;
            foreach (packet_count[k]) begin
                packet_count[k] = '0;
                sample_total[k] = '0;
            end
            integ_len = LEN_RESET;
            expected_bins.delete();
            mismatches = 0;
        end else begin
            // compare first: a result beat always belongs to an earlier input beat
            if (i_out_valid && !i_out_stall) begin
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: element %0d bin %0d power %h total %h last %b",
                                 i_out_element, i_out_bin, i_summed_power, i_total_samples,
                                 i_last_of_spectrum);
                end else begin
                    oldest_bin = expected_bins.pop_front();
                    if (oldest_bin.element !== i_out_element || oldest_bin.bin_no !== i_out_bin ||
                        oldest_bin.power !== i_summed_power || oldest_bin.total !== i_total_samples ||
                        oldest_bin.last !== i_last_of_spectrum) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch, wanted: element %0d bin %0d power %h total %h last %b",
                                     oldest_bin.element, oldest_bin.bin_no, oldest_bin.power,
                                     oldest_bin.total, oldest_bin.last);
                            $display("          got:    element %0d bin %0d power %h total %h last %b",
                                     i_out_element, i_out_bin, i_summed_power, i_total_samples,
                                     i_last_of_spectrum);
                        end
                    end
                end
            end
            if (i_cfg_we)
                integ_len = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                integrate_beat(i_element_index, i_bin_index, i_power_value, i_packet_samples,
                               i_end_of_packet);
        end
        o_mismatch_count <= mismatches;
        o_waiting_count  <= expected_bins.size();
    end

endmodule

FILE: tb/sv/tb_per_element_spectrum_integrator.sv
module tb_per_element_spectrum_integrator;
    import pesi_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    // full-scale beats piled onto one bin inside a single packet
    localparam int OVERRUN_BEATS = 40;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;

    logic               cfg_we    = 1'b0;
    logic [LEN_W-1:0]   cfg_wdata = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ELEM_W-1:0]  element_index  = '0;
    logic [BIN_W-1:0]   bin_index      = '0;
    logic [POWER_W-1:0] power_value    = '0;
    logic [SAMP_W-1:0]  packet_samples = '0;
    logic               end_of_packet  = 1'b0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ELEM_W-1:0]  out_element;
    logic [BIN_W-1:0]   out_bin;
    logic [ACC_W-1:0]   summed_power;
    logic [TOTAL_W-1:0] total_samples;
    logic               last_of_spectrum;

    int                 mismatch_count;
    int                 waiting_count;
    int                 cycles     = 0;
    int                 stall_hold = 0;
    bit                 calm       = 1'b0;

    always #5 clk = ~clk;

    per_element_spectrum_integrator dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_element_index    (element_index),
        .i_bin_index        (bin_index),
        .i_power_value      (power_value),
        .i_packet_samples   (packet_samples),
        .i_end_of_packet    (end_of_packet),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_element      (out_element),
        .o_out_bin          (out_bin),
        .o_summed_power     (summed_power),
        .o_total_samples    (total_samples),
        .o_last_of_spectrum (last_of_spectrum)
    );

    spectrum_integrator_checker integ_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_element_index    (element_index),
        .i_bin_index        (bin_index),
        .i_power_value      (power_value),
        .i_packet_samples   (packet_samples),
        .i_end_of_packet    (end_of_packet),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_element      (out_element),
        .i_out_bin          (out_bin),
        .i_summed_power     (summed_power),
        .i_total_samples    (total_samples),
        .i_last_of_spectrum (last_of_spectrum),
        .o_mismatch_count   (mismatch_count),
        .o_waiting_count    (waiting_count)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(negedge clk) begin
        if (calm) begin
            out_stall  = 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            out_stall = ($urandom_range(0, 2) == 0);
            if (out_stall)
                stall_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 3);
            else
                stall_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(0, 5);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [POWER_W-1:0] pick_power();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return POWER_W'($urandom_range(0, 255));
            3:       return POWER_W'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // called just after a falling edge, returns just after the falling edge following acceptance
    task automatic send_beat(input int elem, input int bin_no, input logic [POWER_W-1:0] power,
                             input int samples, input bit eop);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       = 1'b1;
        element_index  = ELEM_W'(elem);
        bin_index      = BIN_W'(bin_no);
        power_value    = power;
        packet_samples = SAMP_W'(samples);
        end_of_packet  = eop;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (waiting_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_length(input int len);
        hold_until_drained();
        cfg_we    = 1'b1;
        cfg_wdata = LEN_W'(len);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_packet(input int elem, input int first_bin, input int nbins);
        for (int k = 0; k < nbins; k++)
            send_beat(elem, first_bin + k, pick_power(), $urandom_range(0, 65535),
                      k == nbins - 1);
    endtask

    task automatic run_phase(input int len, input int beats, input bit quiet);
        int sent;
        int nbins;
        int first_bin;
        int r;
        set_length(len);
        calm = quiet;
        sent = 0;
        while (sent < beats) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                // stray beat with every field random, framing included
                send_beat($urandom_range(0, NUM_ELEMENTS - 1), $urandom_range(0, NUM_BINS - 1),
                          $urandom, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                if (r < 80)
                    nbins = $urandom_range(1, 4);
                else if (r < 97)
                    nbins = $urandom_range(5, 16);
                else
                    nbins = $urandom_range(32, 64);
                // keep start bins clustered so packets overlap in the accumulators
                case ($urandom_range(0, 3))
                    0:       first_bin = $urandom_range(0, NUM_BINS - nbins);
                    1:       first_bin = 0;
                    2:       first_bin = NUM_BINS - nbins;
                    default: first_bin = 8 * $urandom_range(0, 7);
                endcase
                send_packet($urandom_range(0, NUM_ELEMENTS - 1), first_bin, nbins);
                sent += nbins;
                if (r >= 98)
                    hold_until_drained();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // length out of reset: the sixteenth packet of the element dumps
        repeat (16) send_beat(2, NUM_BINS - 1, '1, 65535, 1'b1);

        set_length(1);
        send_beat(0, 0, '0, 0, 1'b1);
        // a dump in mid-packet carries no sample total
        send_beat(1, 5, 32'hA5A5_A5A5, 16'h5A5A, 1'b0);
        send_beat(1, 5, 32'h5A5A_5A5A, 16'hA5A5, 1'b1);

        // zero length behaves as one
        set_length(0);
        send_beat(3, 512, 32'h0000_0001, 65535, 1'b1);

        set_length(65535);
        send_beat(0, 9, 32'h8000_0000, 1, 1'b0);
        send_beat(0, 9, 32'h7FFF_FFFF, 2, 1'b0);
        send_beat(0, 9, 32'hFFFF_FFFF, 65535, 1'b1);
        send_beat(0, 9, 32'h0000_0100, 3, 1'b1);

        // length lowered to the element count: next packet dumps
        set_length(2);
        send_beat(0, 9, 32'h0000_0001, 4, 1'b1);

        // one bin loaded with full-scale beats inside a single packet, then dumped
        calm = 1'b1;
        repeat (OVERRUN_BEATS) send_beat(1, 100, '1, 0, 1'b0);
        send_beat(1, 100, '1, 65535, 1'b1);
        send_beat(1, 100, 32'h0000_0005, 65535, 1'b1);
        calm = 1'b0;

        run_phase(1, 250, 1'b0);
        run_phase(2, 250, 1'b1);
        run_phase(3, 250, 1'b0);
        run_phase(16, 300, 1'b0);
        run_phase(0, 200, 1'b0);
        run_phase(4, 250, 1'b1);
        run_phase(65535, 100, 1'b0);
        run_phase(2, 150, 1'b0);

        hold_until_drained();
        if (mismatch_count == 0 && waiting_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: per_element_spectrum_integrator.f
sv/pesi_pkg.sv
sv/pesi_ram.sv
sv/per_element_spectrum_integrator.sv
tb/sv/spectrum_integrator_checker.sv
tb/sv/tb_per_element_spectrum_integrator.sv
